>>> hw/rtl/hbr_pkg.sv
// ----------------------------------------------------------------------------
// hbr_pkg
// Shared types and constants for the HSV background replacement block.
// ----------------------------------------------------------------------------
package hbr_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_DEV_MULT     = 2'd2
  } cfg_index_t;

  localparam int CFG_DATA_W = 12;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1366;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd768;
  localparam logic [7:0]  DEV_MULT_RST     = 8'd40;

  localparam int MIN_DIM = 3;

  // Hue sector scaling, quarter degrees
  localparam int HUE_SCALE = 240;
  localparam int HUE_OFS_G = 480;
  localparam int HUE_OFS_B = 960;
  localparam int SAT_SCALE = 1024;

  // Divider geometry: quotient below 2^Q_W, denominator one color byte
  localparam int Q_W   = 11;
  localparam int DEN_W = 8;
  localparam int NUM_W = Q_W + DEN_W;

  typedef struct packed {
    logic [7:0]         cam_blue;
    logic [7:0]         cam_green;
    logic [7:0]         cam_red;
    logic [7:0]         bg_blue;
    logic [7:0]         bg_green;
    logic [7:0]         bg_red;
    logic signed [11:0] hue_mean;
    logic [10:0]        sat_mean;
    logic [10:0]        hue_dev;
    logic [10:0]        sat_dev;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       was_replaced;
    logic       end_of_frame;
    logic       last_of_run;
  } out_item_t;

  // Division request: hue and saturation numerators and denominators
  typedef struct packed {
    logic [NUM_W-1:0] num_h;
    logic [NUM_W-1:0] num_s;
    logic [DEN_W-1:0] den_h;
    logic [DEN_W-1:0] den_s;
    logic             neg;   // red sector with green below blue
    logic             flat;  // max equals min
  } div_req_t;

  typedef struct packed {
    logic [Q_W-1:0] hue_q;
    logic [Q_W-1:0] sat_q;
    logic           neg;
    logic           flat;
  } div_res_t;

endpackage

>>> hw/rtl/hbr_ram.sv
// ----------------------------------------------------------------------------
// hbr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/hbr_conv.sv
// ----------------------------------------------------------------------------
// hbr_conv
// Color front end: max/min, chroma, and the hue/saturation numerators.
// ----------------------------------------------------------------------------
module hbr_conv #(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  hbr_pkg::in_item_t in_item,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_v,
  output hbr_pkg::div_req_t out_req,
  output logic [TAG_W-1:0]  out_tag
);
  import hbr_pkg::*;

  logic              v_r;
  div_req_t          req_r, req_nxt;
  logic [TAG_W-1:0]  tag_r;

  always_comb begin
    int b, g, r, hi, lo, c, nh, ns;
    b  = int'(in_item.cam_blue);
    g  = int'(in_item.cam_green);
    r  = int'(in_item.cam_red);
    hi = (r > g) ? r : g;
    hi = (b > hi) ? b : hi;
    lo = (r < g) ? r : g;
    lo = (b < lo) ? b : lo;
    c  = hi - lo;
    req_nxt.neg = 1'b0;
    if (hi == r) begin
      if (g < b) begin
        nh = HUE_SCALE * (b - g);
        req_nxt.neg = 1'b1;
      end else begin
        nh = HUE_SCALE * (g - b);
      end
    end else if (hi == g) begin
      nh = HUE_SCALE * (b - r) + HUE_OFS_G * c;
    end else begin
      nh = HUE_SCALE * (r - g) + HUE_OFS_B * c;
    end
    ns = SAT_SCALE * c;
    req_nxt.num_h = nh[NUM_W-1:0];
    req_nxt.num_s = ns[NUM_W-1:0];
    req_nxt.den_h = c[DEN_W-1:0];
    req_nxt.den_s = hi[DEN_W-1:0];
    req_nxt.flat  = (c == 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req_r <= req_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_v   = v_r;
  assign out_req = req_r;
  assign out_tag = tag_r;

endmodule

>>> hw/rtl/hbr_div.sv
// ----------------------------------------------------------------------------
// hbr_div
// Pipelined restoring dividers for hue and saturation, one quotient bit
// per stage, with a pass-through tag.
// ----------------------------------------------------------------------------
module hbr_div #(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  hbr_pkg::div_req_t in_req,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_v,
  output hbr_pkg::div_res_t out_res,
  output logic [TAG_W-1:0]  out_tag
);
  import hbr_pkg::*;

  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic nb,
                                               input logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, DEN_W'(t - {1'b0, den})};
    end else begin
      div_step = {1'b0, t[DEN_W-1:0]};
    end
  endfunction

  logic             v_r   [Q_W];
  div_req_t         req_r [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];
  logic [DEN_W-1:0] rh_r  [Q_W];
  logic [DEN_W-1:0] rs_r  [Q_W];
  logic [Q_W-1:0]   qh_r  [Q_W];
  logic [Q_W-1:0]   qs_r  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             v_in;
    div_req_t         req_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W-1:0] rh_in, rs_in;
    logic [Q_W-1:0]   qh_in, qs_in;
    logic [DEN_W:0]   sh, ss;
    logic [Q_W-1:0]   qh_nxt, qs_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_v;
      assign req_in = in_req;
      assign tag_in = in_tag;
      assign rh_in  = in_req.num_h[NUM_W-1:Q_W];
      assign rs_in  = in_req.num_s[NUM_W-1:Q_W];
      assign qh_in  = '0;
      assign qs_in  = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign req_in = req_r[k-1];
      assign tag_in = tag_r[k-1];
      assign rh_in  = rh_r[k-1];
      assign rs_in  = rs_r[k-1];
      assign qh_in  = qh_r[k-1];
      assign qs_in  = qs_r[k-1];
    end

    always_comb begin
      sh = div_step(rh_in, req_in.num_h[Q_W-1-k], req_in.den_h);
      ss = div_step(rs_in, req_in.num_s[Q_W-1-k], req_in.den_s);
      qh_nxt = qh_in;
      qs_nxt = qs_in;
      qh_nxt[Q_W-1-k] = sh[DEN_W];
      qs_nxt[Q_W-1-k] = ss[DEN_W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        req_r[k] <= req_in;
        tag_r[k] <= tag_in;
        rh_r[k]  <= sh[DEN_W-1:0];
        rs_r[k]  <= ss[DEN_W-1:0];
        qh_r[k]  <= qh_nxt;
        qs_r[k]  <= qs_nxt;
      end
    end
  end

  assign out_v         = v_r[Q_W-1];
  assign out_tag       = tag_r[Q_W-1];
  assign out_res.hue_q = qh_r[Q_W-1];
  assign out_res.sat_q = qs_r[Q_W-1];
  assign out_res.neg   = req_r[Q_W-1].neg;
  assign out_res.flat  = req_r[Q_W-1].flat;

endmodule

>>> hw/rtl/hsv_background_replace.sv
// ----------------------------------------------------------------------------
// hsv_background_replace
// Background test in hue/saturation space with cross dilation of the mask
// and replacement of background pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one camera pixel per transfer, with its replacement pixel and
//           the learned hue/saturation mean and deviation, in raster order.
//   out_* : result pixels. Results lag one row: the transfer at column x of
//           row y yields the pixel (x, y-1). Row 0 yields nothing; each
//           transfer of the last row yields two results, the pixel above
//           and then the current pixel itself (last_of_run on the second).
//   cfg_* : write-only registers, written while the block is idle.
// Pipeline: input transfer, front end, 11-stage divider, threshold,
//   dilation and output register; the divider sets the latency.
// Throughput: one pixel per cycle while results can leave; a last-row pixel
//   yields two results and holds the input while the first leaves. The line
//   stores are read one stage ahead of the dilation.
// Reset: clears position counters, pipeline valid bits and registers to
//   their defaults. Line stores are not cleared.
// Stall: with out_ready low and a result in the output register the whole
//   pipeline holds; in_ready drops while that result cannot leave, and in
//   the cycle the first of the two results of a last-row pixel leaves.
// ----------------------------------------------------------------------------
module hsv_background_replace #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hbr_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hbr_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [hbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hbr_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Sideband carried with each pixel down the pipeline
  typedef struct packed {
    logic [AW-1:0]      x;
    logic               y_gt0;     // row above exists: emit
    logic               y_ge2;     // center row not the top border
    logic               last_row;
    logic               x_last;
    logic               x_in;      // center column not a border column
    logic [23:0]        cam;       // {r, g, b}
    logic [23:0]        bg;        // {r, g, b}
    logic signed [11:0] hue_mean;
    logic [10:0]        sat_mean;
    logic [10:0]        hue_dev;
    logic [10:0]        sat_dev;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [11:0] frame_width_r, frame_height_r;
  logic [7:0]  dev_mult_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      dev_mult_r     <= DEV_MULT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        CFG_DEV_MULT:     dev_mult_r     <= cfg_data[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: everything moves unless the output register is stuck
  // --------------------------------------------------------------------------
  logic      adv;
  logic      ob_vld_r, ob_two_r, ob_phase_r, ob_eof1_r;
  out_item_t ob_r0_r;
  logic [23:0] ob_pix1_r;
  logic      ob_done;

  assign ob_done  = ob_vld_r && out_ready && (ob_phase_r || !ob_two_r);
  assign adv      = !ob_vld_r || ob_done;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Raster position, resolved at the input transfer
  // --------------------------------------------------------------------------
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  tag_t          in_tag;

  always_comb begin
    int w, h, x, y, nx, ny;
    w = int'(frame_width_r);
    h = int'(frame_height_r);
    w = (w < MIN_DIM) ? MIN_DIM : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    h = (h < MIN_DIM) ? MIN_DIM : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    x = int'(col_r);
    y = int'(row_r);
    // wrap a count left behind by a shrunk dimension
    if (x >= w) begin
      x = 0;
      y = y + 1;
    end
    if (y >= h) begin
      y = 0;
    end
    nx = x + 1;
    ny = y;
    if (nx >= w) begin
      nx = 0;
      ny = y + 1;
      if (ny >= h) begin
        ny = 0;
      end
    end
    col_nxt = nx[AW-1:0];
    row_nxt = ny[RW-1:0];

    in_tag.x        = x[AW-1:0];
    in_tag.y_gt0    = (y > 0);
    in_tag.y_ge2    = (y >= 2);
    in_tag.last_row = (y == h - 1);
    in_tag.x_last   = (x == w - 1);
    in_tag.x_in     = (x >= 1) && (x + 2 <= w);
    in_tag.cam      = {in_data.cam_red, in_data.cam_green, in_data.cam_blue};
    in_tag.bg       = {in_data.bg_red, in_data.bg_green, in_data.bg_blue};
    in_tag.hue_mean = in_data.hue_mean;
    in_tag.sat_mean = in_data.sat_mean;
    in_tag.hue_dev  = in_data.hue_dev;
    in_tag.sat_dev  = in_data.sat_dev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_valid && in_ready) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Front end and dividers
  // --------------------------------------------------------------------------
  logic             cv_v, dv_v;
  div_req_t         cv_req;
  div_res_t         dv_res;
  logic [TAG_W-1:0] cv_tag, dv_tag;

  hbr_conv #(.TAG_W(TAG_W)) u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (in_valid),
    .in_item (in_data),
    .in_tag  (in_tag),
    .out_v   (cv_v),
    .out_req (cv_req),
    .out_tag (cv_tag)
  );

  hbr_div #(.TAG_W(TAG_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (cv_v),
    .in_req  (cv_req),
    .in_tag  (cv_tag),
    .out_v   (dv_v),
    .out_res (dv_res),
    .out_tag (dv_tag)
  );

  // --------------------------------------------------------------------------
  // Threshold stage: distances and scaled deviations
  // --------------------------------------------------------------------------
  tag_t        dtag;
  logic        m1_v_r;
  tag_t        m1_tag_r;
  logic [11:0] m1_dh_r, dh_nxt;
  logic [10:0] m1_ds_r, ds_nxt;
  logic [18:0] m1_ph_r, m1_ps_r;

  assign dtag = tag_t'(dv_tag);

  always_comb begin
    int hue, sat, dh, ds;
    hue = dv_res.flat ? 0 : (dv_res.neg ? -int'(dv_res.hue_q) : int'(dv_res.hue_q));
    sat = dv_res.flat ? 0 : int'(dv_res.sat_q);
    dh  = int'(dtag.hue_mean) - hue;
    ds  = int'(dtag.sat_mean) - sat;
    dh  = (dh < 0) ? -dh : dh;
    ds  = (ds < 0) ? -ds : ds;
    dh_nxt = dh[11:0];
    ds_nxt = ds[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_tag_r <= dtag;
      m1_dh_r  <= dh_nxt;
      m1_ds_r  <= ds_nxt;
      m1_ph_r  <= 19'(dev_mult_r) * 19'(dtag.hue_dev);
      m1_ps_r  <= 19'(dev_mult_r) * 19'(dtag.sat_dev);
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: read as an item enters the dilation stage, write as it
  // leaves. Mask bit 0 is the newest row, bit 1 the row before.
  // --------------------------------------------------------------------------
  logic          m2_v_r;
  tag_t          m2_tag_r;
  logic [11:0]   m2_dh_r;
  logic [10:0]   m2_ds_r;
  logic [18:0]   m2_ph_r, m2_ps_r;
  logic [1:0]    old_mask, right_mask;
  logic [47:0]   prev_pix;
  logic          left_r;
  logic          ram_we;
  logic [AW-1:0] raddr_right;
  logic          bg_bit;

  assign ram_we      = adv && m2_v_r;
  assign raddr_right = m1_tag_r.x + AW'(1);

  hbr_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_mask_ctr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (m2_tag_r.x),
    .wdata ({old_mask[0], bg_bit}),
    .re    (adv),
    .raddr (m1_tag_r.x),
    .rdata (old_mask)
  );

  hbr_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_mask_rgt (
    .clk   (clk),
    .we    (ram_we),
    .waddr (m2_tag_r.x),
    .wdata ({old_mask[0], bg_bit}),
    .re    (adv),
    .raddr (raddr_right),
    .rdata (right_mask)
  );

  hbr_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_pix_row (
    .clk   (clk),
    .we    (ram_we),
    .waddr (m2_tag_r.x),
    .wdata ({m2_tag_r.bg, m2_tag_r.cam}),
    .re    (adv),
    .raddr (m1_tag_r.x),
    .rdata (prev_pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (adv) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_tag_r <= m1_tag_r;
      m2_dh_r  <= m1_dh_r;
      m2_ds_r  <= m1_ds_r;
      m2_ph_r  <= m1_ph_r;
      m2_ps_r  <= m1_ps_r;
    end
    // left neighbor in the row above: the previous pixel's center mask
    if (ram_we) begin
      left_r <= old_mask[0];
    end
  end

  // --------------------------------------------------------------------------
  // Dilation and result assembly
  // --------------------------------------------------------------------------
  logic      rep;
  out_item_t res0;

  assign bg_bit = (19'({m2_dh_r, 4'b0000}) <= m2_ph_r) &&
                  (19'({m2_ds_r, 4'b0000}) <= m2_ps_r);

  always_comb begin
    logic dil;
    logic [23:0] pix;
    dil = old_mask[0] | old_mask[1] | bg_bit | left_r | right_mask[0];
    rep = m2_tag_r.x_in && m2_tag_r.y_ge2 && dil;
    pix = rep ? prev_pix[47:24] : prev_pix[23:0];
    res0.out_blue     = pix[7:0];
    res0.out_green    = pix[15:8];
    res0.out_red      = pix[23:16];
    res0.was_replaced = rep;
    res0.end_of_frame = 1'b0;
    res0.last_of_run  = !m2_tag_r.last_row;
  end

  // --------------------------------------------------------------------------
  // Output register: one or two results per pixel
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_vld_r   <= 1'b0;
      ob_phase_r <= 1'b0;
    end else if (adv) begin
      ob_vld_r   <= m2_v_r && m2_tag_r.y_gt0;
      ob_phase_r <= 1'b0;
    end else if (ob_vld_r && out_ready) begin
      // first of two results went out: advance to the second
      ob_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_r0_r   <= res0;
      ob_two_r  <= m2_tag_r.last_row;
      ob_pix1_r <= m2_tag_r.cam;
      ob_eof1_r <= m2_tag_r.x_last;
    end
  end

  assign out_valid = ob_vld_r;

  always_comb begin
    if (ob_phase_r) begin
      out_data.out_blue     = ob_pix1_r[7:0];
      out_data.out_green    = ob_pix1_r[15:8];
      out_data.out_red      = ob_pix1_r[23:16];
      out_data.was_replaced = 1'b0;
      out_data.end_of_frame = ob_eof1_r;
      out_data.last_of_run  = 1'b1;
    end else begin
      out_data = ob_r0_r;
    end
  end

`ifndef SYNTHESIS
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_vld_r && ob_two_r && !ob_phase_r && out_ready) |=> (ob_vld_r && ob_phase_r))
    else $error("second result of a last-row pixel lost");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && (!out_ready || (ob_two_r && !ob_phase_r))))
    else $error("input stalled without output backpressure");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_frame) |-> out_data.last_of_run)
    else $error("end of frame on a result that is not last of run");

  a_rep_not_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.was_replaced) |-> !out_data.end_of_frame)
    else $error("bottom border pixel marked replaced");
`endif

endmodule
